FILE: rtl/core/l1c_pkg.sv
`default_nettype none
package l1c_pkg;

    localparam int SET_COUNT_DEF = 16384;
    localparam int DATA_WAYS_DEF = 8;
    localparam int INST_WAYS_DEF = 4;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 12;
    localparam int TAG_LSB  = 20;
    localparam int SET_LSB  = 6;
    localparam int LINE_W   = 26;
    localparam int FK_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 32;

    localparam logic [OP_W-1:0] OP_DREAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_DWRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_IFETCH = 3'd2;
    localparam logic [OP_W-1:0] OP_SNINV  = 3'd3;
    localparam logic [OP_W-1:0] OP_SNRFO  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [FK_W-1:0] FK_NONE = 2'd0;
    localparam logic [FK_W-1:0] FK_READ = 2'd1;
    localparam logic [FK_W-1:0] FK_RFO  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_S  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OP = 2'd2;

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_M = 2'd1,
        MESI_E = 2'd2,
        MESI_S = 2'd3
    } t_mesi;

    typedef enum logic [2:0] {
        S_SWEEP_RST,
        S_IDLE,
        S_UPDATE,
        S_SWEEP_CLR,
        S_CLR_REPORT
    } t_state;

    typedef struct packed {
        logic read;
        logic commit;
        logic sweep;
        logic clr_cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_done;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/core/l1c_if.sv
`default_nettype none
interface l1c_req_if import l1c_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

interface l1c_rsp_if import l1c_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic                evict_valid;
    logic [LINE_W-1:0]   evict_line;
    logic [FK_W-1:0]     fetch_kind;
    logic                own_line_write;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    data_reads;
    logic [CNT_W-1:0]    data_writes;
    logic [CNT_W-1:0]    data_hits;
    logic [CNT_W-1:0]    inst_reads;
    logic [CNT_W-1:0]    inst_hits;

    modport source (output valid, output hit, output evict_valid, output evict_line,
                    output fetch_kind, output own_line_write, output status,
                    output data_reads, output data_writes, output data_hits,
                    output inst_reads, output inst_hits, input ready);
    modport sink (input valid, input hit, input evict_valid, input evict_line,
                  input fetch_kind, input own_line_write, input status,
                  input data_reads, input data_writes, input data_hits,
                  input inst_reads, input inst_hits, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/l1c_ctrl.sv
`default_nettype none
module l1c_ctrl import l1c_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_in_ready,
    input  wire t_dp_status      i_status,
    output t_dp_cmd              o_cmd
);

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP_RST;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP_RST: begin
                if (i_status.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = (i_op == OP_CLEAR) ? S_SWEEP_CLR : S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SWEEP_CLR: begin
                if (i_status.sweep_done) n_state = S_CLR_REPORT;
            end
            S_CLR_REPORT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_SWEEP_RST;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_SWEEP_RST: begin
                o_cmd.sweep = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.read    = i_in_valid;
                o_cmd.clr_cnt = i_in_valid && (i_op == OP_CLEAR);
            end
            S_UPDATE, S_CLR_REPORT: begin
                o_cmd.commit = i_status.out_free;
            end
            S_SWEEP_CLR: begin
                o_cmd.sweep = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_CLEAR) |=> (r_state == S_SWEEP_CLR))
        else $error("clear request did not start a sweep");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> !o_in_ready)
        else $error("request taken during sweep");

endmodule
`default_nettype wire

FILE: rtl/core/l1c_datapath.sv
`default_nettype none
module l1c_datapath import l1c_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int DATA_WAYS = DATA_WAYS_DEF,
    parameter int INST_WAYS = INST_WAYS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_hit,
    output logic                   o_evict_valid,
    output logic [LINE_W-1:0]      o_evict_line,
    output logic [FK_W-1:0]        o_fetch_kind,
    output logic                   o_own_line_write,
    output logic [STATUS_W-1:0]    o_status_code,
    output logic [CNT_W-1:0]       o_data_reads,
    output logic [CNT_W-1:0]       o_data_writes,
    output logic [CNT_W-1:0]       o_data_hits,
    output logic [CNT_W-1:0]       o_inst_reads,
    output logic [CNT_W-1:0]       o_inst_hits
);

    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int DRANK_W = $clog2(DATA_WAYS);
    localparam int IRANK_W = $clog2(INST_WAYS);
    localparam logic [DRANK_W-1:0] DRANK_MRU = DRANK_W'(DATA_WAYS - 1);
    localparam logic [IRANK_W-1:0] IRANK_MRU = IRANK_W'(INST_WAYS - 1);
    localparam logic [SET_W-1:0]   SET_LAST  = SET_W'(SET_COUNT - 1);

    typedef logic [DATA_WAYS-1:0][TAG_W-1:0]   t_dtag_row;
    typedef t_mesi [DATA_WAYS-1:0]             t_dcoh_row;
    typedef logic [DATA_WAYS-1:0][DRANK_W-1:0] t_drank_row;
    typedef logic [DATA_WAYS-1:0]              t_dtch_row;
    typedef logic [INST_WAYS-1:0][TAG_W-1:0]   t_itag_row;
    typedef logic [INST_WAYS-1:0]              t_ival_row;
    typedef logic [INST_WAYS-1:0][IRANK_W-1:0] t_irank_row;

    t_dtag_row  r_dtag_mem  [SET_COUNT];
    t_dcoh_row  r_dcoh_mem  [SET_COUNT];
    t_drank_row r_drank_mem [SET_COUNT];
    t_dtch_row  r_dtch_mem  [SET_COUNT];
    t_itag_row  r_itag_mem  [SET_COUNT];
    t_ival_row  r_ival_mem  [SET_COUNT];
    t_irank_row r_irank_mem [SET_COUNT];

    t_dtag_row  r_dtag,  n_dtag;
    t_dcoh_row  r_dcoh,  n_dcoh;
    t_drank_row r_drank, n_drank;
    t_dtch_row  r_dtch,  n_dtch;
    t_itag_row  r_itag,  n_itag;
    t_ival_row  r_ival,  n_ival;
    t_irank_row r_irank, n_irank;

    logic [OP_W-1:0]  r_op;
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic [SET_W-1:0] r_sweep_idx;

    logic [CNT_W-1:0] r_dreads, n_dreads, r_dwrites, n_dwrites, r_dhits, n_dhits;
    logic [CNT_W-1:0] r_ireads, n_ireads, r_ihits, n_ihits;

    logic                r_out_valid;
    logic                n_hit, n_ev, n_own;
    logic [LINE_W-1:0]   n_evl;
    logic [FK_W-1:0]     n_fk;
    logic [STATUS_W-1:0] n_st;

    logic               w_dhit, w_ihit;
    logic [DRANK_W-1:0] w_dway, w_dvic, w_duse, w_dold;
    logic [DRANK_W:0]   w_best;
    logic [IRANK_W-1:0] w_iway, w_ivic, w_iuse, w_iold;
    t_drank_row         w_dprom;
    t_irank_row         w_iprom;

    assign o_status.sweep_done = (r_sweep_idx == SET_LAST);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // set read at request accept, registered for the update cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_op    <= i_op;
            r_tag   <= i_address[TAG_LSB +: TAG_W];
            r_set   <= i_address[SET_LSB +: SET_W];
            r_dtag  <= r_dtag_mem[i_address[SET_LSB +: SET_W]];
            r_dcoh  <= r_dcoh_mem[i_address[SET_LSB +: SET_W]];
            r_drank <= r_drank_mem[i_address[SET_LSB +: SET_W]];
            r_dtch  <= r_dtch_mem[i_address[SET_LSB +: SET_W]];
            r_itag  <= r_itag_mem[i_address[SET_LSB +: SET_W]];
            r_ival  <= r_ival_mem[i_address[SET_LSB +: SET_W]];
            r_irank <= r_irank_mem[i_address[SET_LSB +: SET_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_dtag_mem[r_sweep_idx]  <= '0;
            r_dcoh_mem[r_sweep_idx]  <= {DATA_WAYS{MESI_I}};
            r_drank_mem[r_sweep_idx] <= '0;
            r_dtch_mem[r_sweep_idx]  <= '0;
            r_itag_mem[r_sweep_idx]  <= '0;
            r_ival_mem[r_sweep_idx]  <= '0;
            r_irank_mem[r_sweep_idx] <= '0;
        end else if (i_cmd.commit && r_op != OP_CLEAR) begin
            r_dtag_mem[r_set]  <= n_dtag;
            r_dcoh_mem[r_set]  <= n_dcoh;
            r_drank_mem[r_set] <= n_drank;
            r_dtch_mem[r_set]  <= n_dtch;
            r_itag_mem[r_set]  <= n_itag;
            r_ival_mem[r_set]  <= n_ival;
            r_irank_mem[r_set] <= n_irank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_idx <= (r_sweep_idx == SET_LAST) ? '0 : r_sweep_idx + 1'b1;
        end
    end

    // data and instruction lookup, victim choice, rank promotion
    always_comb begin
        w_dhit = 1'b0;
        w_dway = '0;
        for (int i = 0; i < DATA_WAYS; i++) begin
            if (r_dtag[i] == r_tag && r_dcoh[i] != MESI_I) begin
                w_dhit = 1'b1;
                w_dway = DRANK_W'(i);
            end
        end
        // last way of rank zero, overridden by the lowest-ranked invalid way
        w_dvic = '0;
        for (int i = 0; i < DATA_WAYS; i++) begin
            if (r_drank[i] == '0) w_dvic = DRANK_W'(i);
        end
        w_best = (DRANK_W+1)'(DATA_WAYS);
        for (int i = 0; i < DATA_WAYS; i++) begin
            if (r_dcoh[i] == MESI_I && {1'b0, r_drank[i]} < w_best) begin
                w_best = {1'b0, r_drank[i]};
                w_dvic = DRANK_W'(i);
            end
        end
        w_duse = w_dhit ? w_dway : w_dvic;
        w_dold = r_drank[w_duse];
        w_dprom = r_drank;
        for (int i = 0; i < DATA_WAYS; i++) begin
            if (r_drank[i] > w_dold) w_dprom[i] = r_drank[i] - 1'b1;
        end
        w_dprom[w_duse] = DRANK_MRU;

        w_ihit = 1'b0;
        w_iway = '0;
        for (int i = 0; i < INST_WAYS; i++) begin
            if (r_itag[i] == r_tag && r_ival[i]) begin
                w_ihit = 1'b1;
                w_iway = IRANK_W'(i);
            end
        end
        w_ivic = '0;
        for (int i = INST_WAYS - 1; i >= 0; i--) begin
            if (r_irank[i] == '0) w_ivic = IRANK_W'(i);
        end
        w_iuse = w_ihit ? w_iway : w_ivic;
        w_iold = r_irank[w_iuse];
        w_iprom = r_irank;
        for (int i = 0; i < INST_WAYS; i++) begin
            if (r_irank[i] > w_iold) w_iprom[i] = r_irank[i] - 1'b1;
        end
        w_iprom[w_iuse] = IRANK_MRU;
    end

    always_comb begin
        n_dtag    = r_dtag;
        n_dcoh    = r_dcoh;
        n_drank   = r_drank;
        n_dtch    = r_dtch;
        n_itag    = r_itag;
        n_ival    = r_ival;
        n_irank   = r_irank;
        n_dreads  = r_dreads;
        n_dwrites = r_dwrites;
        n_dhits   = r_dhits;
        n_ireads  = r_ireads;
        n_ihits   = r_ihits;
        n_hit     = 1'b0;
        n_ev      = 1'b0;
        n_evl     = '0;
        n_fk      = FK_NONE;
        n_own     = 1'b0;
        n_st      = STATUS_OK;
        case (r_op)
            OP_DREAD, OP_DWRITE: begin
                if (r_op == OP_DREAD) n_dreads = r_dreads + 1'b1;
                else n_dwrites = r_dwrites + 1'b1;
                n_drank = w_dprom;
                if (w_dhit) begin
                    n_hit   = 1'b1;
                    n_dhits = r_dhits + 1'b1;
                    if (r_dcoh[w_duse] != MESI_M) begin
                        n_dcoh[w_duse] = (r_op == OP_DREAD) ? MESI_S : MESI_M;
                    end
                end else begin
                    if (r_dcoh[w_duse] == MESI_M) begin
                        n_ev  = 1'b1;
                        n_evl = LINE_W'({r_dtag[w_duse], r_set});
                    end
                    if (r_op == OP_DREAD) begin
                        n_fk = FK_READ;
                        n_dcoh[w_duse] = MESI_E;
                    end else begin
                        n_fk = FK_RFO;
                        if (!r_dtch[w_duse]) begin
                            // cold line is written through and kept exclusive
                            n_own = 1'b1;
                            n_dcoh[w_duse] = MESI_E;
                        end else begin
                            n_dcoh[w_duse] = MESI_M;
                        end
                    end
                    n_dtag[w_duse] = r_tag;
                end
                n_dtch[w_duse] = 1'b1;
            end
            OP_IFETCH: begin
                n_ireads = r_ireads + 1'b1;
                n_irank  = w_iprom;
                if (w_ihit) begin
                    n_hit   = 1'b1;
                    n_ihits = r_ihits + 1'b1;
                end else begin
                    n_fk           = FK_READ;
                    n_ival[w_iuse] = 1'b1;
                    n_itag[w_iuse] = r_tag;
                end
            end
            OP_SNINV: begin
                if (w_dhit) begin
                    n_hit = 1'b1;
                    if (r_dcoh[w_dway] == MESI_S) begin
                        n_dcoh[w_dway] = MESI_I;
                        n_drank        = w_dprom;
                    end else begin
                        n_st = STATUS_NOT_S;
                    end
                end
            end
            OP_SNRFO: begin
                if (w_dhit) begin
                    n_hit          = 1'b1;
                    n_drank        = w_dprom;
                    n_own          = (r_dcoh[w_dway] == MESI_M);
                    n_dcoh[w_dway] = MESI_I;
                end
            end
            OP_CLEAR: begin
                n_hit = 1'b0;
            end
            default: begin
                n_st = STATUS_BAD_OP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_cnt) begin
            r_dreads  <= '0;
            r_dwrites <= '0;
            r_dhits   <= '0;
            r_ireads  <= '0;
            r_ihits   <= '0;
        end else if (i_cmd.commit) begin
            r_dreads  <= n_dreads;
            r_dwrites <= n_dwrites;
            r_dhits   <= n_dhits;
            r_ireads  <= n_ireads;
            r_ihits   <= n_ihits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit            <= n_hit;
            o_evict_valid    <= n_ev;
            o_evict_line     <= n_evl;
            o_fetch_kind     <= n_fk;
            o_own_line_write <= n_own;
            o_status_code    <= n_st;
            o_data_reads     <= n_dreads;
            o_data_writes    <= n_dwrites;
            o_data_hits      <= n_dhits;
            o_inst_reads     <= n_ireads;
            o_inst_hits      <= n_ihits;
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending result");

    a_hit_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_hit) |-> (n_fk == FK_NONE && !n_ev))
        else $error("hit with fetch or writeback");

    a_evict_needs_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_ev) |-> (n_fk != FK_NONE))
        else $error("writeback without fill");

endmodule
`default_nettype wire

FILE: rtl/core/split_l1_cache_mesi_lru_controller.sv
`default_nettype none
// split L1 tag and state controller: 8-way MESI data cache, 4-way instruction
// cache, rank-counter true LRU in both
// request channel carries op and address; response channel returns one
// result per request: hit, victim writeback, fill kind, own-line write,
// status and the five statistics counters after the request
// a request is taken in the idle cycle, the set is read from the tag/state
// memories on that edge, and the result is computed and written back in the
// update state once the output register is free; each request does a single
// read-then-write of the set memories and is done before the next is taken
// the result sits in an output register; a request can be taken while it
// waits, but the following update holds until the receiver takes the result
// after reset the memories are swept one set per cycle, with the request
// channel not ready; a clear request runs the same sweep and its result is
// registered after the sweep, once the output register is free
module split_l1_cache_mesi_lru_controller import l1c_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int DATA_WAYS = DATA_WAYS_DEF,
    parameter int INST_WAYS = INST_WAYS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    l1c_req_if.sink   i_req,
    l1c_rsp_if.source o_rsp
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    l1c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_op       (i_req.op),
        .o_in_ready (i_req.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    l1c_datapath #(
        .SET_COUNT (SET_COUNT),
        .DATA_WAYS (DATA_WAYS),
        .INST_WAYS (INST_WAYS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (i_req.op),
        .i_address        (i_req.address),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_hit            (o_rsp.hit),
        .o_evict_valid    (o_rsp.evict_valid),
        .o_evict_line     (o_rsp.evict_line),
        .o_fetch_kind     (o_rsp.fetch_kind),
        .o_own_line_write (o_rsp.own_line_write),
        .o_status_code    (o_rsp.status),
        .o_data_reads     (o_rsp.data_reads),
        .o_data_writes    (o_rsp.data_writes),
        .o_data_hits      (o_rsp.data_hits),
        .o_inst_reads     (o_rsp.inst_reads),
        .o_inst_hits      (o_rsp.inst_hits)
    );

endmodule
`default_nettype wire
